/* design/fstm_pkg.sv */
// ----------------------------------------------------------------------------
// fstm_pkg
// Shared types and constants of the flat span texture mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package fstm_pkg;

  // screen and flat geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int FLAT_EDGE_LOG = 6;
  localparam int FRAC_BITS     = 16;

  // stores
  localparam int TEXEL_DEPTH = 4096;
  localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
  localparam int SHADE_DEPTH = 256;
  localparam int SHADE_AW    = $clog2(SHADE_DEPTH);
  localparam int PIX_W       = 8;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_LOAD_TEXEL = 2'd0;
  localparam logic [1:0] CMD_LOAD_SHADE = 2'd1;
  localparam logic [1:0] CMD_START_SPAN = 2'd2;
  localparam logic [1:0] CMD_NEXT_PIXEL = 2'd3;

  // register select (paddr bit 2, registers at 4-byte spacing)
  localparam logic REG_FLAT_SIZE_SHIFT = 1'b0;

  // input transaction
  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        load_address;
    logic [7:0]         load_value;
    logic [7:0]         row;
    logic [8:0]         x_start;
    logic [8:0]         x_end;
    logic signed [31:0] u_start;
    logic signed [31:0] v_start;
    logic signed [31:0] u_step;
    logic signed [31:0] v_step;
  } fstm_in_t;

  // output transaction
  typedef struct packed {
    logic [15:0] pixel_address;
    logic [7:0]  pixel_value;
    logic        last;
  } fstm_out_t;

  // store accesses issued by the span sequencer
  typedef struct packed {
    logic                texel_we;
    logic [TEXEL_AW-1:0] texel_waddr;
    logic [PIX_W-1:0]    texel_wdata;
    logic [TEXEL_AW-1:0] texel_raddr;
    logic                shade_we;
    logic [SHADE_AW-1:0] shade_waddr;
    logic [PIX_W-1:0]    shade_wdata;
  } fstm_mem_req_t;

  // pixel tag that travels beside the store reads
  typedef struct packed {
    logic        valid;
    logic [15:0] pixel_address;
    logic        last;
  } fstm_tag_t;

endpackage

`default_nettype wire

/* design/fstm_ram.sv */
// ----------------------------------------------------------------------------
// fstm_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the contents before a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* design/fstm_span.sv */
// ----------------------------------------------------------------------------
// fstm_span
// Command decode and span sequencer: store writes, accumulators, texel fetch.
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_span
  import fstm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          acc,
  input  wire fstm_in_t      item,
  input  wire logic [2:0]    flat_size_shift,
  output      fstm_mem_req_t req,
  output      fstm_tag_t     tag
);

  logic [31:0] u_accum;
  logic [31:0] v_accum;
  logic [31:0] u_increment;
  logic [31:0] v_increment;
  logic [8:0]  pixels_left;
  logic [15:0] dest_address;
  logic        busy;

  logic        step_go;
  logic        start_go;
  logic        span_empty;
  logic [15:0] start_address;

  // flat index from the integer parts of the accumulators
  function automatic logic [TEXEL_AW-1:0] texel_index(
    input logic [31:0] u,
    input logic [31:0] v,
    input logic [2:0]  shift_reg
  );
    logic [2:0]          s;
    logic [31:0]         us;
    logic [31:0]         vs;
    logic [5:0]          umask;
    logic [TEXEL_AW-1:0] vmask;
    s     = (shift_reg > 3'(FLAT_EDGE_LOG)) ? 3'(FLAT_EDGE_LOG) : shift_reg;
    us    = u >> (6'(FRAC_BITS) + 6'(s));
    vs    = v >> (6'(FRAC_BITS - FLAT_EDGE_LOG) + {2'b0, s, 1'b0});
    umask = 6'h3f >> s;
    vmask = TEXEL_AW'(umask) << (3'(FLAT_EDGE_LOG) - s);
    return (TEXEL_AW'(us[5:0] & umask)) | (vs[TEXEL_AW-1:0] & vmask);
  endfunction

  assign step_go       = acc && (item.command == CMD_NEXT_PIXEL) && busy;
  assign start_go      = acc && (item.command == CMD_START_SPAN);
  assign span_empty    = item.x_end < item.x_start;
  assign start_address = 16'({8'b0, item.row} * 16'(SCREEN_WIDTH)) + 16'(item.x_start);

  // store writes and the texel read for this pixel
  always_comb begin
    req.texel_we    = acc && (item.command == CMD_LOAD_TEXEL);
    req.texel_waddr = item.load_address;
    req.texel_wdata = item.load_value;
    req.texel_raddr = texel_index(u_accum, v_accum, flat_size_shift);
    req.shade_we    = acc && (item.command == CMD_LOAD_SHADE) &&
                      (item.load_address[11:SHADE_AW] == '0);
    req.shade_waddr = item.load_address[SHADE_AW-1:0];
    req.shade_wdata = item.load_value;
  end

  // tag of the pixel whose texel is being read
  always_comb begin
    tag.valid         = step_go;
    tag.pixel_address = dest_address;
    tag.last          = (pixels_left == 9'd0);
  end

  // span state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start_go) begin
      busy <= !span_empty;
    end else if (step_go && (pixels_left == 9'd0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_go && !span_empty) begin
      pixels_left  <= item.x_end - item.x_start;
      dest_address <= start_address;
      u_accum      <= $unsigned(item.u_start);
      v_accum      <= $unsigned(item.v_start);
      u_increment  <= $unsigned(item.u_step);
      v_increment  <= $unsigned(item.v_step);
    end else if (step_go) begin
      pixels_left  <= (pixels_left == 9'd0) ? pixels_left : pixels_left - 9'd1;
      dest_address <= dest_address + 16'd1;
      u_accum      <= u_accum + u_increment;
      v_accum      <= v_accum + v_increment;
    end
  end

`ifndef SYNTHESIS
  // final pixel of a span ends it unless a new span starts
  a_last_clears_busy: assert property (@(posedge clk) disable iff (rst)
    step_go && (pixels_left == 9'd0) |=> !busy)
    else $error("span stayed busy after its last pixel");

  // an empty span never leaves the sequencer busy
  a_empty_span_idle: assert property (@(posedge clk) disable iff (rst)
    start_go && span_empty |=> !busy && !tag.valid)
    else $error("empty span started drawing");
`endif

endmodule

`default_nettype wire

/* design/fstm_outq.sv */
// ----------------------------------------------------------------------------
// fstm_outq
// Small result queue that decouples the fetch pipeline from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_outq
  import fstm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire fstm_out_t             push_item,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      fstm_out_t             out_item,
  output      logic [OUTQ_CNT_W-1:0] count
);

  fstm_out_t             entry [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_item  = entry[rd_ptr];
  assign pop       = out_valid && !out_stall;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  // fill level stays within the queue
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OUTQ_CNT_W'(OUTQ_DEPTH))
    else $error("result queue count out of range");

  // input credit check keeps a full queue from being written
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != OUTQ_CNT_W'(OUTQ_DEPTH)) || pop)
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

/* design/flat_span_texture_mapper_top.sv */
// ----------------------------------------------------------------------------
// flat_span_texture_mapper_top
// Textured span drawer: texel store, shade map and pixel output queue.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while in_stall is low, loads and
// span commands alike. A next-pixel transaction while a span is running
// reads the texel store at the edge that accepts it, then the shade map,
// and the pixel then lands in a four-entry result queue, where a stall on
// the output can hold it. Both stores are synchronous memories with one
// write and one read port. in_stall rises only when the queue plus the
// pixels still in the two read stages fill the queue, so with out_stall
// low pixels stream at one per clock.
// Texel and shade entries that were never loaded read back undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_span_texture_mapper_top
  import fstm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire fstm_in_t    in_item,
  // output channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      fstm_out_t   out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic                  in_acc;
  logic [2:0]            flat_size_shift;
  fstm_mem_req_t         req;
  fstm_tag_t             tag;
  logic [PIX_W-1:0]      texel_rdata;
  logic [PIX_W-1:0]      shade_rdata;
  logic                  s1_valid;
  logic [15:0]           s1_address;
  logic                  s1_last;
  logic                  s2_valid;
  logic [15:0]           s2_address;
  logic                  s2_last;
  fstm_out_t             push_item;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   credits_used;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FLAT_SIZE_SHIFT) ? {29'b0, flat_size_shift} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_size_shift <= 3'd0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_FLAT_SIZE_SHIFT)) begin
      flat_size_shift <= pwdata[2:0];
    end
  end

  // input flow control: reserve queue room for pixels in flight
  assign credits_used = (OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(s1_valid) +
                        (OUTQ_CNT_W + 1)'(s2_valid);
  assign in_stall     = credits_used >= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
  assign in_acc       = in_valid && !in_stall;

  // span sequencer
  fstm_span u_span (
    .clk             (clk),
    .rst             (rst),
    .acc             (in_acc),
    .item            (in_item),
    .flat_size_shift (flat_size_shift),
    .req             (req),
    .tag             (tag)
  );

  // texel store
  fstm_ram #(.WIDTH(PIX_W), .DEPTH(TEXEL_DEPTH)) u_texel_ram (
    .clk   (clk),
    .we    (req.texel_we),
    .waddr (req.texel_waddr),
    .wdata (req.texel_wdata),
    .raddr (req.texel_raddr),
    .rdata (texel_rdata)
  );

  // shade map, addressed by the fetched texel
  fstm_ram #(.WIDTH(PIX_W), .DEPTH(SHADE_DEPTH)) u_shade_ram (
    .clk   (clk),
    .we    (req.shade_we),
    .waddr (req.shade_waddr),
    .wdata (req.shade_wdata),
    .raddr (texel_rdata),
    .rdata (shade_rdata)
  );

  // tag stages alongside the two reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= tag.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_address <= tag.pixel_address;
    s1_last    <= tag.last;
    s2_address <= s1_address;
    s2_last    <= s1_last;
  end

  always_comb begin
    push_item.pixel_address = s2_address;
    push_item.pixel_value   = shade_rdata;
    push_item.last          = s2_last;
  end

  // result queue
  fstm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .count     (q_count)
  );

endmodule

`default_nettype wire
